@@ hw/rtl/bcdf_pkg.sv @@
// ----------------------------------------------------------------------------
// bcdf_pkg - bytecode container deframer package
// Types, codes and constants shared by the deframer step logic and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bcdf_pkg;

    // Container sections, in stream order
    typedef enum logic [2:0] {
        SEC_MAGIC   = 3'd0,
        SEC_VERSION = 3'd1,
        SEC_COUNT   = 3'd2,
        SEC_STRLEN  = 3'd3,
        SEC_STRDATA = 3'd4,
        SEC_CODELEN = 3'd5,
        SEC_CODE    = 3'd6,
        SEC_TRAIL   = 3'd7
    } section_t;

    // Byte tag reported with each word
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_STRING  = 2'd1,
        KIND_CODE    = 2'd2,
        KIND_IGNORED = 2'd3
    } kind_t;

    // Running status, sticky error and end-of-container verdict
    typedef enum logic [3:0] {
        ST_RUN      = 4'd0,
        ST_OK       = 4'd1,
        ST_MAGIC    = 4'd2,
        ST_VERSION  = 4'd3,
        ST_COUNT    = 4'd4,
        ST_STRLEN   = 4'd5,
        ST_STRDATA  = 4'd6,
        ST_CODELEN  = 4'd7,
        ST_CODE     = 4'd8
    } status_t;

    localparam int unsigned OUT_BITS   = 8 + 32 + 1 + 64 + 4;
    localparam int unsigned TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // Parser state carried between words
    typedef struct packed {
        section_t     section;
        logic [2:0]   pos;
        logic [63:0]  accum;
        logic [31:0]  strings_left;
        logic [31:0]  str_bytes_left;
        logic [63:0]  code_bytes_left;
        logic [31:0]  str_index;
        status_t      err;
    } parse_state_t;

    // One result word
    typedef struct packed {
        logic [7:0]   byte_out;
        kind_t        kind;
        logic [31:0]  string_number;
        logic         field_done;
        logic [63:0]  field_value;
        status_t      status;
    } result_t;

    localparam parse_state_t STATE_RESET = '{
        section:         SEC_MAGIC,
        pos:             3'd0,
        accum:           64'd0,
        strings_left:    32'd0,
        str_bytes_left:  32'd0,
        code_bytes_left: 64'd0,
        str_index:       32'd0,
        err:             ST_RUN
    };

    // Magic "CXBC", first byte first
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h43;
            2'd1:    b = 8'h58;
            2'd2:    b = 8'h42;
            default: b = 8'h43;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bcdf_step.sv @@
// ----------------------------------------------------------------------------
// bcdf_step - one-byte parse step
// Combinational next-state and result for one container byte.
// ----------------------------------------------------------------------------
`default_nettype none

module bcdf_step (
    input  bcdf_pkg::parse_state_t cur,
    input  logic [7:0]             byte_in,
    input  logic                   last_byte,
    input  logic [31:0]            expected_version,
    output bcdf_pkg::parse_state_t nxt,
    output bcdf_pkg::result_t      res
);

    logic [63:0] acc_new;
    logic [2:0]  pos_inc;
    logic [31:0] sl_dec;
    logic [31:0] sb_dec;
    logic [63:0] cb_dec;
    bcdf_pkg::parse_state_t upd;

    assign pos_inc = cur.pos + 3'd1;
    assign sl_dec  = cur.strings_left - 32'd1;
    assign sb_dec  = cur.str_bytes_left - 32'd1;
    assign cb_dec  = cur.code_bytes_left - 64'd1;

    always_comb begin
        acc_new = cur.accum;
        acc_new[{cur.pos, 3'b000} +: 8] = byte_in;
    end

    always_comb begin
        upd               = cur;
        res.byte_out      = byte_in;
        res.kind          = bcdf_pkg::KIND_HEADER;
        res.string_number = 32'd0;
        res.field_done    = 1'b0;
        res.field_value   = 64'd0;
        res.status        = bcdf_pkg::ST_RUN;

        if (cur.err != bcdf_pkg::ST_RUN) begin
            res.kind = bcdf_pkg::KIND_IGNORED;
        end else begin
            case (cur.section)
                bcdf_pkg::SEC_MAGIC: begin
                    if (byte_in != bcdf_pkg::magic_byte(cur.pos[1:0])) begin
                        upd.err = bcdf_pkg::ST_MAGIC;
                    end
                    if (cur.pos[1:0] == 2'd3) begin
                        upd.pos     = 3'd0;
                        upd.accum   = 64'd0;
                        upd.section = bcdf_pkg::SEC_VERSION;
                    end else begin
                        upd.pos = {1'b0, pos_inc[1:0]};
                    end
                end
                bcdf_pkg::SEC_VERSION: begin
                    if (cur.pos == 3'd3) begin
                        if (acc_new[31:0] != expected_version) begin
                            upd.err = bcdf_pkg::ST_VERSION;
                        end
                        upd.pos     = 3'd0;
                        upd.accum   = 64'd0;
                        upd.section = bcdf_pkg::SEC_COUNT;
                    end else begin
                        upd.pos   = pos_inc;
                        upd.accum = acc_new;
                    end
                end
                bcdf_pkg::SEC_COUNT: begin
                    if (cur.pos == 3'd3) begin
                        res.field_done    = 1'b1;
                        res.field_value   = {32'd0, acc_new[31:0]};
                        upd.strings_left  = acc_new[31:0];
                        upd.str_index     = 32'd0;
                        upd.pos           = 3'd0;
                        upd.accum         = 64'd0;
                        upd.section       = (acc_new[31:0] == 32'd0) ?
                                            bcdf_pkg::SEC_CODELEN : bcdf_pkg::SEC_STRLEN;
                    end else begin
                        upd.pos   = pos_inc;
                        upd.accum = acc_new;
                    end
                end
                bcdf_pkg::SEC_STRLEN: begin
                    res.string_number = cur.str_index;
                    if (cur.pos == 3'd3) begin
                        res.field_done     = 1'b1;
                        res.field_value    = {32'd0, acc_new[31:0]};
                        upd.str_bytes_left = acc_new[31:0];
                        upd.pos            = 3'd0;
                        upd.accum          = 64'd0;
                        if (acc_new[31:0] == 32'd0) begin
                            // empty string: close it right here
                            upd.str_index    = cur.str_index + 32'd1;
                            upd.strings_left = sl_dec;
                            upd.section      = (sl_dec == 32'd0) ?
                                               bcdf_pkg::SEC_CODELEN : bcdf_pkg::SEC_STRLEN;
                        end else begin
                            upd.section = bcdf_pkg::SEC_STRDATA;
                        end
                    end else begin
                        upd.pos   = pos_inc;
                        upd.accum = acc_new;
                    end
                end
                bcdf_pkg::SEC_STRDATA: begin
                    res.kind           = bcdf_pkg::KIND_STRING;
                    res.string_number  = cur.str_index;
                    upd.str_bytes_left = sb_dec;
                    if (sb_dec == 32'd0) begin
                        upd.str_index    = cur.str_index + 32'd1;
                        upd.strings_left = sl_dec;
                        upd.section      = (sl_dec == 32'd0) ?
                                           bcdf_pkg::SEC_CODELEN : bcdf_pkg::SEC_STRLEN;
                    end
                end
                bcdf_pkg::SEC_CODELEN: begin
                    if (cur.pos == 3'd7) begin
                        res.field_done      = 1'b1;
                        res.field_value     = acc_new;
                        upd.code_bytes_left = acc_new;
                        upd.pos             = 3'd0;
                        upd.accum           = 64'd0;
                        upd.section         = (acc_new == 64'd0) ?
                                              bcdf_pkg::SEC_TRAIL : bcdf_pkg::SEC_CODE;
                    end else begin
                        upd.pos   = pos_inc;
                        upd.accum = acc_new;
                    end
                end
                bcdf_pkg::SEC_CODE: begin
                    res.kind            = bcdf_pkg::KIND_CODE;
                    upd.code_bytes_left = cb_dec;
                    if (cb_dec == 64'd0) begin
                        upd.section = bcdf_pkg::SEC_TRAIL;
                    end
                end
                default: begin
                    res.kind = bcdf_pkg::KIND_IGNORED;
                end
            endcase
        end

        // verdict on the final byte, then start over
        if (!last_byte) begin
            res.status = upd.err;
            nxt        = upd;
        end else begin
            if (upd.err != bcdf_pkg::ST_RUN) begin
                res.status = upd.err;
            end else begin
                case (upd.section)
                    bcdf_pkg::SEC_MAGIC:   res.status = bcdf_pkg::ST_MAGIC;
                    bcdf_pkg::SEC_VERSION: res.status = bcdf_pkg::ST_MAGIC;
                    bcdf_pkg::SEC_COUNT:   res.status = bcdf_pkg::ST_COUNT;
                    bcdf_pkg::SEC_STRLEN:  res.status = bcdf_pkg::ST_STRLEN;
                    bcdf_pkg::SEC_STRDATA: res.status = bcdf_pkg::ST_STRDATA;
                    bcdf_pkg::SEC_CODELEN: res.status = bcdf_pkg::ST_CODELEN;
                    bcdf_pkg::SEC_CODE:    res.status = bcdf_pkg::ST_CODE;
                    default:               res.status = bcdf_pkg::ST_OK;
                endcase
            end
            nxt = bcdf_pkg::STATE_RESET;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bytecode_container_deframer.sv @@
// ----------------------------------------------------------------------------
// bytecode_container_deframer - length-prefixed bytecode container deframer
// Usage:
//   s_ channel: one container byte per word in s_tdata, s_tlast on the final
//   byte. Each accepted word yields exactly one m_ word: the byte passed
//   through, its tag in m_tuser (header, string data, code, ignored), the
//   string index, a field-complete flag with the little-endian value of the
//   finished count or length field, and a status code: 0 while parsing is
//   clean, the sticky error code after a fault, and on the s_tlast byte the
//   final verdict (1 ok, 2..8 fault cause).
//   cfg channel: writes the expected header version (resets to 1). Write it
//   only while no container is in flight.
// Timing:
//   m_tvalid rises in the cycle after input accept. Throughput is one byte
//   per cycle while m_tready is high: one pass of counter decrements, a
//   byte-lane insert and compares between the state register and the output register.
// Reset and stall:
//   aresetn low returns the parser to the magic section and empties the
//   output register. When the receiver holds m_tready low, the output word
//   holds and s_tready drops; s_tready is high whenever the output register
//   is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bytecode_container_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [31:0]                         cfg_data,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] byte_in
    input  logic                                s_tlast,   // last_byte
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] byte_out, [39:8] string_number, [40] field_done,
    // [104:41] field_value, [108:105] status, [111:109] zero
    output logic [bcdf_pkg::TDATA_BITS-1:0]     m_tdata,
    output logic [1:0]                          m_tuser    // [1:0] byte_kind
);

    bcdf_pkg::parse_state_t st_reg;
    bcdf_pkg::parse_state_t st_next;
    bcdf_pkg::result_t      res_next;
    bcdf_pkg::result_t      out_reg;
    logic                   m_tvalid_reg;
    logic [31:0]            ver_reg;
    logic                   in_fire;

    // Accept a new byte whenever the output slot is free or drains now
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    bcdf_step u_step (
        .cur              (st_reg),
        .byte_in          (s_tdata),
        .last_byte        (s_tlast),
        .expected_version (ver_reg),
        .nxt              (st_next),
        .res              (res_next)
    );

    // Version register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ver_reg <= 32'd1;
        end else if (cfg_valid && cfg_ready) begin
            ver_reg <= cfg_data;
        end
    end

    // Parser state: advance on every accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= bcdf_pkg::STATE_RESET;
        end else if (in_fire) begin
            st_reg <= st_next;
        end
    end

    // Output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {{(bcdf_pkg::TDATA_BITS - bcdf_pkg::OUT_BITS){1'b0}},
                       out_reg.status,
                       out_reg.field_value,
                       out_reg.field_done,
                       out_reg.string_number,
                       out_reg.byte_out};

`ifndef SYNTHESIS
    // A completed field is always a header field
    a_done_is_header: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[40] |-> m_tuser == bcdf_pkg::KIND_HEADER)
        else $error("field_done on a non-header byte");

    // The final byte returns the parser to its start
    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_tlast |=> st_reg.section == bcdf_pkg::SEC_MAGIC &&
                               st_reg.err == bcdf_pkg::ST_RUN && st_reg.pos == 3'd0)
        else $error("parser not cleared after last byte");

    // Once an error is recorded, following bytes are ignored
    a_err_ignores: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && st_reg.err != bcdf_pkg::ST_RUN |=>
            m_tuser == bcdf_pkg::KIND_IGNORED && !m_tdata[40])
        else $error("byte after error not tagged ignored");

    // Field position stays within the longest field
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.section != bcdf_pkg::SEC_CODELEN |-> st_reg.pos[2] == 1'b0)
        else $error("field position out of range");
`endif

endmodule

`default_nettype wire
